// ===== rtl/core/kwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsd_pkg
// Shared types and constants for the keypad and wheel scancode decoder.
// ----------------------------------------------------------------------------
package kwsd_pkg;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-1:0] REG_THIRD_GEN_MODE = 3'd0;

	localparam logic [6:0] SC_CTRL = 7'd29;
	localparam logic [6:0] SC_Q    = 7'd16;
	localparam logic [6:0] SC_S    = 7'd31;
	localparam logic [6:0] SC_L    = 7'd38;
	localparam logic [6:0] SC_R    = 7'd19;

	localparam logic [7:0] SPUR_SRC = 8'h40;
	localparam logic [7:0] SPUR_LVL = 8'hbf;

	localparam int HOLD_BIT = 5;
	localparam int NUM_BTN  = 5;

	localparam logic [6:0] BTN_CODE [NUM_BTN] = '{7'd33, 7'd28, 7'd32, 7'd17, 7'd50};

	localparam logic [2:0] HOLD_EVENTS  = 3'd4;
	localparam logic [1:0] WHEEL_EVENTS = 2'd2;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BWD  = 2'd2
	} wheel_dir_t;

	// one queued word: what is still to be sent for one input event
	typedef struct packed {
		logic [2:0]         hold_cnt;
		logic               hold_s;
		logic [NUM_BTN-1:0] btn_mask;
		logic [NUM_BTN-1:0] btn_lvl;
		logic [1:0]         whl_cnt;
		logic               whl_l;
	} plan_t;

	// Gray-code step: 0->1->3->2->0 is forward
	function automatic wheel_dir_t wheel_dir(input logic [1:0] prev, input logic [1:0] now);
		wheel_dir_t d;
		d = DIR_NONE;
		unique case ({prev, now})
			4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: d = DIR_FWD;
			4'b01_00, 4'b11_01, 4'b10_11, 4'b00_10: d = DIR_BWD;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/kwsd_front.sv =====
// ----------------------------------------------------------------------------
// kwsd_front
// Classifies pin-change events, tracks wheel and hold state, builds plans.
// ----------------------------------------------------------------------------
module kwsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                third_gen_mode,
	input  logic                accept,
	input  logic [7:0]          source_mask,
	input  logic [7:0]          pin_levels,
	output logic                plan_push,
	output kwsd_pkg::plan_t     plan
);

	logic       take;
	logic [1:0] prev_wheel_q;
	logic       known_q;
	logic       hrr_q;
	logic [1:0] prev_wheel_d;
	logic       known_d;
	logic       hrr_d;
	logic       spurious;
	logic       hold_hit;
	logic       send_s;
	logic       stop;
	logic [1:0] now;
	kwsd_pkg::wheel_dir_t dir;

	assign now = pin_levels[7:6];
	assign dir = kwsd_pkg::wheel_dir(prev_wheel_q, now);

	always_comb begin
		spurious = third_gen_mode & hrr_q & (source_mask == kwsd_pkg::SPUR_SRC)
			& (pin_levels == kwsd_pkg::SPUR_LVL);
		hold_hit = source_mask[kwsd_pkg::HOLD_BIT];
		send_s = third_gen_mode ? ~pin_levels[kwsd_pkg::HOLD_BIT]
			: pin_levels[kwsd_pkg::HOLD_BIT];
		stop = hold_hit & third_gen_mode;

		hrr_d = third_gen_mode ? 1'b0 : hrr_q;
		if (stop && !send_s) begin
			hrr_d = 1'b1;
		end

		plan = '0;
		plan.hold_cnt = hold_hit ? kwsd_pkg::HOLD_EVENTS : 3'd0;
		plan.hold_s = send_s;
		plan.btn_mask = stop ? '0 : source_mask[kwsd_pkg::NUM_BTN-1:0];
		plan.btn_lvl = pin_levels[kwsd_pkg::NUM_BTN-1:0];

		prev_wheel_d = prev_wheel_q;
		known_d = known_q;
		if (!stop && (source_mask[7:6] != 2'b00)) begin
			prev_wheel_d = now;
			known_d = 1'b1;
			if (known_q && dir != kwsd_pkg::DIR_NONE) begin
				plan.whl_cnt = kwsd_pkg::WHEEL_EVENTS;
				plan.whl_l = (dir == kwsd_pkg::DIR_FWD);
			end
		end
	end

	// valid item: ours and not the post-hold glitch
	assign take = accept & (source_mask != 8'd0) & ~spurious;
	assign plan_push = take & ((plan.hold_cnt != 3'd0) | (plan.btn_mask != '0)
		| (plan.whl_cnt != 2'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_wheel_q <= 2'd0;
			known_q <= 1'b0;
			hrr_q <= 1'b0;
		end else if (take) begin
			prev_wheel_q <= prev_wheel_d;
			known_q <= known_d;
			hrr_q <= hrr_d;
		end
	end

endmodule

// ===== rtl/core/kwsd_fifo.sv =====
// ----------------------------------------------------------------------------
// kwsd_fifo
// Four-word plan queue between the front and back parts.
// ----------------------------------------------------------------------------
module kwsd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  kwsd_pkg::plan_t wr_data,
	input  logic            rd_en,
	output kwsd_pkg::plan_t rd_data,
	output logic            full,
	output logic            empty
);

	kwsd_pkg::plan_t mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'd0, do_wr} - {2'd0, do_rd};
		end
	end

endmodule

// ===== rtl/core/kwsd_back.sv =====
// ----------------------------------------------------------------------------
// kwsd_back
// Walks one plan per input event; emits one key event per cycle while popped.
// ----------------------------------------------------------------------------
module kwsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  kwsd_pkg::plan_t head,
	input  logic            q_empty,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [6:0]      scancode,
	output logic            pressed,
	output logic            last_of_run
);

	kwsd_pkg::plan_t work_q;
	kwsd_pkg::plan_t cur;
	kwsd_pkg::plan_t nxt;
	logic       busy_q;
	logic       out_valid_q;
	logic [6:0] code_q;
	logic       press_q;
	logic       last_q;
	logic [6:0] code;
	logic       press;
	logic       last;
	logic       have;
	logic       fire;
	logic [2:0] idx;

	assign cur  = busy_q ? work_q : head;
	assign have = busy_q | ~q_empty;
	assign fire = have & (~out_valid_q | pop);
	assign q_pop = fire & ~busy_q;

	always_comb begin
		nxt = cur;
		code = kwsd_pkg::SC_CTRL;
		press = 1'b0;
		idx = 3'd0;
		for (int i = kwsd_pkg::NUM_BTN - 1; i >= 0; i--) begin
			if (cur.btn_mask[i]) begin
				idx = 3'(i);
			end
		end
		if (cur.hold_cnt != 3'd0) begin
			nxt.hold_cnt = cur.hold_cnt - 3'd1;
			unique case (cur.hold_cnt)
				3'd4: begin
					code = kwsd_pkg::SC_CTRL;
					press = 1'b1;
				end
				3'd3: begin
					code = cur.hold_s ? kwsd_pkg::SC_S : kwsd_pkg::SC_Q;
					press = 1'b1;
				end
				3'd2: begin
					code = cur.hold_s ? kwsd_pkg::SC_S : kwsd_pkg::SC_Q;
					press = 1'b0;
				end
				default: begin
					code = kwsd_pkg::SC_CTRL;
					press = 1'b0;
				end
			endcase
		end else if (cur.btn_mask != '0) begin
			code = kwsd_pkg::BTN_CODE[idx];
			press = ~cur.btn_lvl[idx];
			nxt.btn_mask[idx] = 1'b0;
		end else begin
			code = cur.whl_l ? kwsd_pkg::SC_L : kwsd_pkg::SC_R;
			press = (cur.whl_cnt == kwsd_pkg::WHEEL_EVENTS);
			nxt.whl_cnt = cur.whl_cnt - 2'd1;
		end
		last = (nxt.hold_cnt == 3'd0) & (nxt.btn_mask == '0) & (nxt.whl_cnt == 2'd0);
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			work_q <= nxt;
			code_q <= code;
			press_q <= press;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q <= ~last;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = ~out_valid_q;
	assign scancode = code_q;
	assign pressed = press_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/core/keypad_wheel_scancode_decoder_unit.sv =====
// First key event of an input goes through the plan queue, then the back output register.
// Key events leave one per cycle when popped, up to eleven per input, paced by kwsd_back.
// Inputs are taken every cycle while the four-word plan queue has room.
// Asynchronous active-low reset clears wheel and hold state, queue and mode register.
// ----------------------------------------------------------------------------
// keypad_wheel_scancode_decoder_unit
// Turns hold, button and wheel pin events into scancode press/release words.
// ----------------------------------------------------------------------------
module keypad_wheel_scancode_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kwsd_pkg::APB_AW-1:0]   paddr,
	input  logic [kwsd_pkg::APB_DW-1:0]   pwdata,
	output logic [kwsd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    source_mask,
	input  logic [7:0]                    pin_levels,
	output logic                          empty,
	input  logic                          pop,
	output logic [6:0]                    scancode,
	output logic                          pressed,
	output logic                          last_of_run
);

	logic            mode_q;
	logic            reg_hit;
	logic            plan_push;
	logic            q_pop;
	logic            q_empty;
	kwsd_pkg::plan_t plan;
	kwsd_pkg::plan_t head;

	assign pready = 1'b1;
	assign reg_hit = (paddr[kwsd_pkg::APB_AW-1:2]
		== kwsd_pkg::REG_THIRD_GEN_MODE[kwsd_pkg::APB_AW-1:2]);
	assign prdata = reg_hit ? {{(kwsd_pkg::APB_DW-1){1'b0}}, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mode_q <= pwdata[0];
		end
	end

	kwsd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.third_gen_mode (mode_q),
		.accept         (push & ~full),
		.source_mask    (source_mask),
		.pin_levels     (pin_levels),
		.plan_push      (plan_push),
		.plan           (plan)
	);

	kwsd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (plan_push),
		.wr_data (plan),
		.rd_en   (q_pop),
		.rd_data (head),
		.full    (full),
		.empty   (q_empty)
	);

	kwsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.scancode    (scancode),
		.pressed     (pressed),
		.last_of_run (last_of_run)
	);

endmodule

// ===== bench/kwsd_key_checker.sv =====
// ----------------------------------------------------------------------------
// kwsd_key_checker
// Watches the register port and both queue sides of the scancode decoder,
// predicts the key words each accepted pin event should produce, and compares
// every popped word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kwsd_key_checker
	import kwsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	input  logic              push,
	input  logic              full,
	input  logic [7:0]        source_mask,
	input  logic [7:0]        pin_levels,
	input  logic              empty,
	input  logic              pop,
	input  logic [6:0]        scancode,
	input  logic              pressed,
	input  logic              last_of_run,
	output int                errors,
	output int                pending,
	output int                keys_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [6:0] KEY_CTRL = 7'd29;
	localparam logic [6:0] KEY_Q    = 7'd16;
	localparam logic [6:0] KEY_S    = 7'd31;
	localparam logic [6:0] KEY_L    = 7'd38;
	localparam logic [6:0] KEY_R    = 7'd19;
	localparam logic [6:0] BUTTON_KEY [5] = '{7'd33, 7'd28, 7'd32, 7'd17, 7'd50};

	localparam logic [7:0] HOLD_PIN   = 8'h20;
	localparam logic [7:0] WHEEL_PINS = 8'hc0;
	localparam logic [7:0] GLITCH_SRC = 8'h40;
	localparam logic [7:0] GLITCH_LVL = 8'hbf;

	typedef struct packed {
		logic [6:0] code;
		logic       down;
		logic       end_of_run;
	} key_word_t;

	key_word_t  expected_keys [$];
	logic       gen3;
	logic [1:0] last_phase;
	logic       phase_seen;
	logic       q_released;

	initial begin
		errors = 0;
		pending = 0;
		keys_checked = 0;
	end

	task automatic add_key(input logic [6:0] code, input logic down);
		expected_keys.push_back('{code, down, 1'b0});
	endtask

	task automatic add_tap(input logic [6:0] key);
		add_key(KEY_CTRL, 1'b1);
		add_key(key, 1'b1);
		add_key(key, 1'b0);
		add_key(KEY_CTRL, 1'b0);
	endtask

	task automatic mark_end_of_run();
		key_word_t w;
		w = expected_keys[expected_keys.size() - 1];
		w.end_of_run = 1'b1;
		expected_keys[expected_keys.size() - 1] = w;
	endtask

	// wheel step from Gray phases: rank = {g1, g1^g0}, +1 forward, -1 backward
	task automatic predict_key_words(input logic [7:0] src, input logic [7:0] lvl);
		int         first;
		logic       s_tap;
		logic [1:0] delta;
		wheel_dir_t dir;
		first = expected_keys.size();
		if (src == 8'h00)
			return;
		if (gen3) begin
			if (q_released && src == GLITCH_SRC && lvl == GLITCH_LVL)
				return;
			q_released = 1'b0;
		end
		if ((src & HOLD_PIN) != 8'h00) begin
			s_tap = gen3 ? ((lvl & HOLD_PIN) == 8'h00) : ((lvl & HOLD_PIN) != 8'h00);
			if (s_tap) begin
				add_tap(KEY_S);
			end else begin
				add_tap(KEY_Q);
				if (gen3)
					q_released = 1'b1;
			end
			if (gen3) begin
				mark_end_of_run();
				return;
			end
		end
		for (int i = 0; i < 5; i++) begin
			if (src[i])
				add_key(BUTTON_KEY[i], !lvl[i]);
		end
		if ((src & WHEEL_PINS) != 8'h00) begin
			if (phase_seen) begin
				delta = {lvl[7], ^lvl[7:6]} - {last_phase[1], ^last_phase};
				dir = (delta == 2'd1) ? DIR_FWD : (delta == 2'd3) ? DIR_BWD : DIR_NONE;
				if (dir == DIR_FWD) begin
					add_key(KEY_L, 1'b1);
					add_key(KEY_L, 1'b0);
				end else if (dir == DIR_BWD) begin
					add_key(KEY_R, 1'b1);
					add_key(KEY_R, 1'b0);
				end
			end
			phase_seen = 1'b1;
			last_phase = lvl[7:6];
		end
		if (expected_keys.size() > first)
			mark_end_of_run();
	endtask

	task automatic report(input string field, input logic [6:0] want_v, input logic [6:0] got_v);
		$display("%0t: key word %0d %s mismatch, expected %0d got %0d",
			$time, keys_checked, field, want_v, got_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_word_t want;
		if (!arst_n) begin
			expected_keys.delete();
			gen3 = 1'b0;
			last_phase = 2'd0;
			phase_seen = 1'b0;
			q_released = 1'b0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_keys.size() == 0) begin
					$display("%0t: unexpected key word, expected none got code %0d pressed %0d last %0d",
						$time, scancode, pressed, last_of_run);
					errors++;
				end else begin
					want = expected_keys.pop_front();
					if (scancode !== want.code)
						report("scancode", want.code, scancode);
					if (pressed !== want.down)
						report("pressed", 7'(want.down), 7'(pressed));
					if (last_of_run !== want.end_of_run)
						report("last_of_run", 7'(want.end_of_run), 7'(last_of_run));
				end
				keys_checked++;
			end
			if (psel && penable && pready && paddr == REG_THIRD_GEN_MODE) begin
				if (pwrite) begin
					gen3 = pwdata[0];
				end else if (prdata !== APB_DW'(gen3)) begin
					$display("%0t: mode readback mismatch, expected %0h got %0h",
						$time, APB_DW'(gen3), prdata);
					errors++;
				end
			end
			if (push && !full)
				predict_key_words(source_mask, pin_levels);
			pending = expected_keys.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives pin events and mode writes into the scancode decoder under random
// input gaps and output stalls, including one long output hold-off that fills
// the block, and reports the verdict from the key word checker.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kwsd_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [1:0] FWD_NEXT [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
	localparam logic [1:0] BWD_NEXT [4] = '{2'b10, 2'b00, 2'b11, 2'b01};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              push;
	logic              full;
	logic [7:0]        source_mask;
	logic [7:0]        pin_levels;
	logic              empty;
	logic              pop;
	logic [6:0]        scancode;
	logic              pressed;
	logic              last_of_run;

	int         errors;
	int         pending;
	int         keys_checked;
	int         events_sent = 0;
	int         mode_writes = 0;
	bit         no_gaps = 1'b0;
	bit         rx_hold_req = 1'b0;
	logic       cur_mode = 1'b0;
	logic [1:0] wheel_now = 2'd0;

	keypad_wheel_scancode_decoder_unit i_dut (.*);

	kwsd_key_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// output side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES - 1;
				pop <= 1'b0;
			end else if (stall_left > 0 && !no_gaps) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic send_event(input logic [7:0] src, input logic [7:0] lvl);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		source_mask <= src;
		pin_levels <= lvl;
		do @(posedge clk); while (full);
		events_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		push <= 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_mode(input logic m, input logic [APB_DW-1:0] upper);
		go_idle();
		reg_access(1'b1, REG_THIRD_GEN_MODE, {upper[APB_DW-1:1], m});
		reg_access(1'b0, REG_THIRD_GEN_MODE, '0);
		cur_mode = m;
		mode_writes++;
	endtask

	task automatic send_random_event();
		int         kind;
		logic [7:0] src;
		logic [7:0] lvl;
		logic [1:0] phase;
		kind = $urandom_range(0, 99);
		lvl = 8'($urandom());
		src = 8'($urandom());
		if (kind < 40) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: phase = FWD_NEXT[wheel_now];
				4, 5, 6, 7: phase = BWD_NEXT[wheel_now];
				8:          phase = wheel_now;
				default:    phase = ~wheel_now;
			endcase
			src = {2'($urandom_range(1, 3)),
				($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'd0};
			lvl[7:6] = phase;
		end else if (kind < 60) begin
			src = 8'($urandom_range(1, 31));
		end else if (kind < 75) begin
			src = 8'(1 << HOLD_BIT) | (($urandom_range(0, 2) == 0) ? src : 8'h00);
		end else if (kind < 85) begin
			// release-type hold tap followed by the stray wheel event
			send_event(8'(1 << HOLD_BIT), {lvl[7:6], cur_mode, lvl[4:0]});
			src = SPUR_SRC;
			lvl = SPUR_LVL;
		end else if (kind >= 95) begin
			src = 8'h00;
		end
		if (src[7:6] != 2'b00)
			wheel_now = lvl[7:6];
		send_event(src, lvl);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		source_mask = 8'h00;
		pin_levels = 8'h00;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0, '0);
		send_event(8'h00, 8'h00);
		send_event(8'hc0, 8'h00);
		send_event(8'h40, 8'h40);
		send_event(8'h80, 8'hc0);
		send_event(8'hc0, 8'h80);
		send_event(8'hc0, 8'h80);
		send_event(8'hc0, 8'h40);
		send_event(8'hc0, 8'h00);
		send_event(8'h20, 8'h20);
		send_event(8'h20, 8'h00);
		send_event(8'h1f, 8'h00);
		send_event(8'h1f, 8'hff);
		send_event(8'hff, 8'h60);
		send_event(8'hff, 8'hff);

		set_mode(1'b1, '1);
		send_event(8'hff, 8'h00);
		send_event(8'h20, 8'h20);
		send_event(SPUR_SRC, SPUR_LVL);
		send_event(8'h20, 8'hff);
		send_event(8'h40, 8'h3f);
		send_event(SPUR_SRC, SPUR_LVL);
		send_event(8'h20, 8'h20);
		send_event(8'h00, 8'h00);
		send_event(SPUR_SRC, SPUR_LVL);
		send_event(8'h01, 8'hfe);
		wheel_now = 2'b10;

		for (int ph = 0; ph < 4; ph++) begin
			set_mode(ph[0], APB_DW'($urandom()));
			no_gaps = (ph == 1);
			if (ph == 2) begin
				@(posedge clk);
				rx_hold_req = 1'b1;
				no_gaps = 1'b1;
				for (int k = 0; k < 30; k++)
					send_event(8'($urandom_range(1, 31)), 8'($urandom()));
				no_gaps = 1'b0;
			end
			for (int k = 0; k < 80; k++)
				send_random_event();
		end
		no_gaps = 1'b0;
		go_idle();

		$display("Sent %0d pin events through %0d mode writes; %0d key words checked,",
			events_sent, mode_writes, keys_checked);
		$display("including a %0d-cycle output hold-off with the input kept busy.",
			HOLD_OFF_CYCLES);
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
